// File: hdl/mbdc_pkg.sv
package mbdc_pkg;

	// Number system and table geometry.
	localparam int WORD_W = 30;
	localparam logic [WORD_W-1:0] PRIME = 30'd1000000007;
	localparam logic [WORD_W-1:0] PRIME_EXP = 30'd1000000005;
	localparam int TABLE_SIZE = 4096;
	localparam int IDX_W = $clog2(TABLE_SIZE);

	// Field widths of the input item.
	localparam int OP_W = 2;
	localparam int N_W = 20;
	localparam int K_W = 12;
	localparam int B_W = 20;

	// Internal widths: binomial top argument, signed remaining total, k times bound.
	localparam int BN_W = 21;
	localparam int M_W = 34;
	localparam int KB_W = K_W + B_W;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_BINOM = 2'd0;
	localparam logic [OP_W-1:0] OP_STARS = 2'd1;
	localparam logic [OP_W-1:0] OP_LOWER = 2'd2;
	localparam logic [OP_W-1:0] OP_UPPER = 2'd3;

	// Request to and answer from the shared modular multiplier.
	typedef struct packed {
		logic start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mm_req_t;

	typedef struct packed {
		logic done;
		logic [WORD_W-1:0] result;
	} mm_rsp_t;

endpackage

// File: hdl/mbdc_ram.sv
module mbdc_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/mbdc_modmul.sv
module mbdc_modmul import mbdc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_req_t req,
	output mm_rsp_t rsp
);

	localparam int STEP_W = $clog2(WORD_W);

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] acc_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [WORD_W:0] dbl;
	logic [WORD_W:0] dbl_r;
	logic [WORD_W:0] sum;
	logic [WORD_W:0] sum_r;

	// One bit of the multiplier per cycle, most significant first:
	// double the partial product and add the multiplicand, reducing after each.
	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
		sum = dbl_r + (b_q[WORD_W-1] ? {1'b0, a_q} : '0);
		sum_r = (sum >= {1'b0, PRIME}) ? sum - {1'b0, PRIME} : sum;
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(WORD_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial product.
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q <= req.a;
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[WORD_W-2:0], 1'b0};
			acc_q <= sum_r[WORD_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = acc_q;

endmodule

// File: hdl/modular_binomial_distribution_count.sv
// Counting block: binomial coefficients and stars-and-bars counts modulo 1000000007.
// Input channel item_valid/item_ready carries operation, total, parts and bound;
// output channel count_valid/count_ready carries one count per item.
// After reset the block builds a factorial table and an inverse-factorial table of
// TABLE_SIZE entries, one modular multiply per entry; the inverse of the last factorial
// takes 45 multiplies. item_ready stays low during this start-up pass. All modular
// products go through one bit-serial modular multiplier, which sets the rate. A
// binomial or stars-and-bars item needs two products; a lower-bounded item first forms
// its remaining total; an upper-bounded item needs five products per inclusion-exclusion
// term, for parts+1 terms. Out-of-range binomials give zero without the table products.
// One item is worked at a time; item_ready is high only when the sequencer is idle. The
// count sits in an output register, so a stalled receiver holds the next item only when
// it finishes before the previous count is taken. Reset clears all control state and
// restarts the table build.
module modular_binomial_distribution_count import mbdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [OP_W-1:0]   operation,
	input  logic [N_W-1:0]    total,
	input  logic [K_W-1:0]    parts,
	input  logic [B_W-1:0]    bound,
	output logic              count_valid,
	input  logic              count_ready,
	output logic [WORD_W-1:0] count
);

	localparam int ST_W = 5;
	localparam logic [ST_W-1:0] S_IDLE = 5'd0;
	localparam logic [ST_W-1:0] S_F0   = 5'd1;
	localparam logic [ST_W-1:0] S_F1   = 5'd2;
	localparam logic [ST_W-1:0] S_F2   = 5'd3;
	localparam logic [ST_W-1:0] S_P1   = 5'd4;
	localparam logic [ST_W-1:0] S_P2   = 5'd5;
	localparam logic [ST_W-1:0] S_P3   = 5'd6;
	localparam logic [ST_W-1:0] S_P4   = 5'd7;
	localparam logic [ST_W-1:0] S_G0   = 5'd8;
	localparam logic [ST_W-1:0] S_G1   = 5'd9;
	localparam logic [ST_W-1:0] S_G2   = 5'd10;
	localparam logic [ST_W-1:0] S_LB   = 5'd11;
	localparam logic [ST_W-1:0] S_LB2  = 5'd12;
	localparam logic [ST_W-1:0] S_SB   = 5'd13;
	localparam logic [ST_W-1:0] S_BC   = 5'd14;
	localparam logic [ST_W-1:0] S_B0   = 5'd15;
	localparam logic [ST_W-1:0] S_B1   = 5'd16;
	localparam logic [ST_W-1:0] S_B2   = 5'd17;
	localparam logic [ST_W-1:0] S_B3   = 5'd18;
	localparam logic [ST_W-1:0] S_B4   = 5'd19;
	localparam logic [ST_W-1:0] S_RET  = 5'd20;
	localparam logic [ST_W-1:0] S_ACC  = 5'd21;
	localparam logic [ST_W-1:0] S_OUT  = 5'd22;

	// Where a binomial evaluation returns to.
	localparam logic [1:0] RET_OUT = 2'd0;
	localparam logic [1:0] RET_W1  = 2'd1;
	localparam logic [1:0] RET_W2  = 2'd2;

	localparam int PC_W = $clog2(WORD_W);
	localparam logic [BN_W-1:0] TS_BN = BN_W'(TABLE_SIZE);

	logic [ST_W-1:0]   state_q;
	logic [1:0]        ret_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [PC_W-1:0]   pc_q;
	logic [WORD_W-1:0] e_q;
	logic [WORD_W-1:0] t_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] base_q;
	logic [WORD_W-1:0] bres_q;
	logic [WORD_W-1:0] w1_q;
	logic [WORD_W-1:0] res_q;
	logic [N_W-1:0]    n_q;
	logic [K_W-1:0]    k_q;
	logic [B_W-1:0]    b_q;
	logic [K_W-1:0]    i_q;
	logic [KB_W-1:0]   kb_q;
	logic [M_W-1:0]    m_q;
	logic [BN_W-1:0]   bn_q;
	logic [K_W-1:0]    br_q;
	logic              count_valid_q;
	logic [WORD_W-1:0] count_q;

	mm_req_t mreq;
	mm_rsp_t mrsp;

	logic              fact_we;
	logic [IDX_W-1:0]  fact_waddr;
	logic [WORD_W-1:0] fact_wdata;
	logic              fact_re;
	logic [IDX_W-1:0]  fact_raddr;
	logic [WORD_W-1:0] fact_rd;
	logic              inv_we;
	logic [IDX_W-1:0]  inv_waddr;
	logic [WORD_W-1:0] inv_wdata;
	logic              inv_re;
	logic [IDX_W-1:0]  inv_raddr;
	logic [WORD_W-1:0] inv_rd;

	logic [BN_W-1:0]   br_ext;
	logic [BN_W-1:0]   bdiff;
	logic [WORD_W-1:0] cnt_ext;
	logic [M_W-1:0]    sb_sum;
	logic [WORD_W:0]   add_s;
	logic [WORD_W-1:0] add_r;
	logic [WORD_W-1:0] sub_r;
	logic [WORD_W-1:0] acc_next;

	mbdc_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	mbdc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_fact_ram (
		.clk   (clk),
		.we    (fact_we),
		.waddr (fact_waddr),
		.wdata (fact_wdata),
		.re    (fact_re),
		.raddr (fact_raddr),
		.rdata (fact_rd)
	);

	mbdc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SIZE)) u_inv_ram (
		.clk   (clk),
		.we    (inv_we),
		.waddr (inv_waddr),
		.wdata (inv_wdata),
		.re    (inv_re),
		.raddr (inv_raddr),
		.rdata (inv_rd)
	);

	// Derived operands for table addressing and the starting point of stars and bars.
	assign br_ext = BN_W'(br_q);
	assign bdiff = bn_q - br_ext;
	assign cnt_ext = WORD_W'(cnt_q);
	assign sb_sum = m_q + M_W'(k_q) - M_W'(1);

	// Signed accumulation of inclusion-exclusion terms; odd terms are subtracted.
	always_comb begin
		add_s = {1'b0, acc_q} + {1'b0, mrsp.result};
		add_r = (add_s >= {1'b0, PRIME}) ? WORD_W'(add_s - {1'b0, PRIME}) : add_s[WORD_W-1:0];
		sub_r = (acc_q >= mrsp.result) ? acc_q - mrsp.result : acc_q + (PRIME - mrsp.result);
		acc_next = i_q[0] ? sub_r : add_r;
	end

	// Multiplier requests and table ports, decoded from the sequencer state.
	always_comb begin
		mreq = '0;
		fact_we = 1'b0;
		fact_waddr = cnt_q;
		fact_wdata = mrsp.result;
		fact_re = 1'b0;
		fact_raddr = bn_q[IDX_W-1:0];
		inv_we = 1'b0;
		inv_waddr = cnt_q - IDX_W'(1);
		inv_wdata = mrsp.result;
		inv_re = 1'b0;
		inv_raddr = br_ext[IDX_W-1:0];
		case (state_q)
			S_F0: begin
				fact_we = 1'b1;
				fact_waddr = '0;
				fact_wdata = WORD_W'(1);
			end
			S_F1: begin
				mreq = '{start: 1'b1, a: t_q, b: cnt_ext};
			end
			S_F2: begin
				fact_we = mrsp.done;
			end
			S_P1: begin
				mreq = '{start: e_q[0], a: acc_q, b: base_q};
			end
			S_P3: begin
				mreq = '{start: 1'b1, a: base_q, b: base_q};
			end
			S_G0: begin
				inv_we = 1'b1;
				inv_waddr = cnt_q;
				inv_wdata = acc_q;
			end
			S_G1: begin
				mreq = '{start: 1'b1, a: t_q, b: cnt_ext};
			end
			S_G2: begin
				inv_we = mrsp.done;
			end
			S_B0: begin
				fact_re = 1'b1;
				inv_re = 1'b1;
			end
			S_B1: begin
				mreq = '{start: 1'b1, a: fact_rd, b: inv_rd};
				inv_re = 1'b1;
				inv_raddr = bdiff[IDX_W-1:0];
			end
			S_B3: begin
				mreq = '{start: 1'b1, a: mrsp.result, b: inv_rd};
			end
			S_RET: begin
				mreq = '{start: (ret_q == RET_W2), a: w1_q, b: bres_q};
			end
			default: begin
			end
		endcase
	end

	// Sequencer: table build, then one item at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_F0;
			ret_q <= RET_OUT;
			cnt_q <= '0;
			pc_q <= '0;
			count_valid_q <= 1'b0;
		end else begin
			if (count_valid_q && count_ready) begin
				count_valid_q <= 1'b0;
			end
			case (state_q)
				// Factorial table, upward.
				S_F0: begin
					t_q <= WORD_W'(1);
					cnt_q <= IDX_W'(1);
					state_q <= S_F1;
				end
				S_F1: begin
					state_q <= S_F2;
				end
				S_F2: begin
					if (mrsp.done) begin
						t_q <= mrsp.result;
						if (cnt_q == IDX_W'(TABLE_SIZE - 1)) begin
							base_q <= mrsp.result;
							acc_q <= WORD_W'(1);
							e_q <= PRIME_EXP;
							pc_q <= '0;
							state_q <= S_P1;
						end else begin
							cnt_q <= cnt_q + IDX_W'(1);
							state_q <= S_F1;
						end
					end
				end
				// Inverse of the last factorial by square-and-multiply.
				S_P1: begin
					state_q <= e_q[0] ? S_P2 : S_P3;
				end
				S_P2: begin
					if (mrsp.done) begin
						acc_q <= mrsp.result;
						state_q <= S_P3;
					end
				end
				S_P3: begin
					state_q <= S_P4;
				end
				S_P4: begin
					if (mrsp.done) begin
						base_q <= mrsp.result;
						e_q <= {1'b0, e_q[WORD_W-1:1]};
						pc_q <= pc_q + PC_W'(1);
						if (pc_q == PC_W'(WORD_W - 1)) begin
							cnt_q <= IDX_W'(TABLE_SIZE - 1);
							state_q <= S_G0;
						end else begin
							state_q <= S_P1;
						end
					end
				end
				// Inverse-factorial table, downward.
				S_G0: begin
					t_q <= acc_q;
					state_q <= S_G1;
				end
				S_G1: begin
					state_q <= S_G2;
				end
				S_G2: begin
					if (mrsp.done) begin
						t_q <= mrsp.result;
						if (cnt_q == IDX_W'(1)) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - IDX_W'(1);
							state_q <= S_G1;
						end
					end
				end
				// Accept an item and route it by operation.
				S_IDLE: begin
					if (item_valid) begin
						n_q <= total;
						k_q <= parts;
						b_q <= bound;
						m_q <= M_W'(total);
						ret_q <= RET_OUT;
						case (operation)
							OP_BINOM: begin
								bn_q <= BN_W'(total);
								br_q <= parts;
								state_q <= S_BC;
							end
							OP_STARS: begin
								state_q <= S_SB;
							end
							OP_LOWER: begin
								state_q <= S_LB;
							end
							OP_UPPER: begin
								acc_q <= '0;
								i_q <= '0;
								bn_q <= BN_W'(parts);
								br_q <= '0;
								ret_q <= RET_W1;
								state_q <= S_BC;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// Lower bound: remaining total is n - k*bound.
				S_LB: begin
					kb_q <= k_q * b_q;
					state_q <= S_LB2;
				end
				S_LB2: begin
					m_q <= M_W'(n_q) - M_W'(kb_q);
					state_q <= S_SB;
				end
				// Stars and bars of m over k parts.
				S_SB: begin
					if (m_q[M_W-1] || k_q == '0) begin
						bres_q <= (m_q == '0 && k_q == '0) ? WORD_W'(1) : '0;
						state_q <= S_RET;
					end else begin
						bn_q <= sb_sum[BN_W-1:0];
						br_q <= k_q - K_W'(1);
						state_q <= S_BC;
					end
				end
				// Binomial of bn over br from the tables.
				S_BC: begin
					if (br_ext > bn_q || bn_q >= TS_BN) begin
						bres_q <= '0;
						state_q <= S_RET;
					end else begin
						state_q <= S_B0;
					end
				end
				S_B0: begin
					state_q <= S_B1;
				end
				S_B1: begin
					state_q <= S_B2;
				end
				S_B2: begin
					if (mrsp.done) begin
						state_q <= S_B3;
					end
				end
				S_B3: begin
					state_q <= S_B4;
				end
				S_B4: begin
					if (mrsp.done) begin
						bres_q <= mrsp.result;
						state_q <= S_RET;
					end
				end
				// Continue with whatever asked for the binomial.
				S_RET: begin
					case (ret_q)
						RET_OUT: begin
							res_q <= bres_q;
							state_q <= S_OUT;
						end
						RET_W1: begin
							w1_q <= bres_q;
							ret_q <= RET_W2;
							state_q <= S_SB;
						end
						RET_W2: begin
							state_q <= S_ACC;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				// Fold one inclusion-exclusion term into the sum.
				S_ACC: begin
					if (mrsp.done) begin
						acc_q <= acc_next;
						if (i_q == k_q) begin
							res_q <= acc_next;
							state_q <= S_OUT;
						end else begin
							i_q <= i_q + K_W'(1);
							m_q <= m_q - M_W'(b_q) - M_W'(1);
							bn_q <= BN_W'(k_q);
							br_q <= i_q + K_W'(1);
							ret_q <= RET_W1;
							state_q <= S_BC;
						end
					end
				end
				// Hand the count to the output register once it is free.
				S_OUT: begin
					if (!count_valid_q || count_ready) begin
						count_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!count_valid_q || count_ready)) begin
			count_q <= res_q;
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign count_valid = count_valid_q;
	assign count = count_q;

endmodule
